@@ design/avd_pkg.sv @@
// Package for the averaging voltmeter display unit.
// Field widths, arithmetic constants, the register map, the stage tag type
// and the seven-segment encoder. Depends on nothing.
package avd_pkg;

  // Averaging window is 2^LOG2_SAMPLES samples
  localparam int LOG2_SAMPLES = 12;

  localparam int SAMPLE_W = 16;
  localparam int DAC_W    = 12;
  localparam int FS_W     = 10;
  localparam int READ_W   = 10;
  localparam int SEG_W    = 8;
  localparam int SUM_W    = SAMPLE_W + LOG2_SAMPLES;
  localparam int CNT_W    = LOG2_SAMPLES;
  localparam int PROD_W   = SAMPLE_W + FS_W;

  localparam int FULL_CODE   = 65535;
  localparam int MAX_READING = 999;

  localparam logic [FS_W-1:0]  FS_RESET   = FS_W'(330);
  localparam logic [SEG_W-1:0] DP_MASK    = 8'h7F;
  localparam logic [SEG_W-1:0] SEG_BLANK  = 8'hFF;

  // Register map (byte address bit 2 selects the register word)
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_FULL_SCALE = 1'b0;

  // Per-item control that travels down the pipe
  typedef struct packed {
    logic [DAC_W-1:0] dac;
    logic             done;
  } tag_t;

  // Active-low segment code of one decimal digit, point dark
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0: code = 8'hc0;
      4'd1: code = 8'hf9;
      4'd2: code = 8'ha4;
      4'd3: code = 8'hb0;
      4'd4: code = 8'h99;
      4'd5: code = 8'h92;
      4'd6: code = 8'h82;
      4'd7: code = 8'hf8;
      4'd8: code = 8'h80;
      4'd9: code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

@@ design/averaging_voltmeter_display_unit.sv @@
// Top level of the averaging voltmeter display unit.
// Instantiates avd_cfg, avd_accum, avd_scale and avd_digits; uses avd_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    in_sample
//   out_     output     out_valid/out_stall  dac_code, average_ready,
//                                            reading_centivolts, seg_*
//   cfg      APB        psel/penable/pready  paddr, pwdata, prdata
//
// One item per cycle sustained while out_stall is low; five register stages
// (accumulate, multiply, divide/latch, digit split, encode) lie between the
// edge that takes an item and the offer of its result.
// Each stage holds a valid bit and fills bubbles, so items keep entering
// while a result waits under out_stall until every stage is full.
// Synchronous active-low reset clears valid bits, sum, count, the latched
// reading and the full-scale register (330); there is no clearing pass.
module averaging_voltmeter_display_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [avd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [avd_pkg::DAC_W-1:0]    out_dac_code,
  output logic                         out_average_ready,
  output logic [avd_pkg::READ_W-1:0]   out_reading_centivolts,
  output logic [avd_pkg::SEG_W-1:0]    out_seg_hundreds,
  output logic [avd_pkg::SEG_W-1:0]    out_seg_tens,
  output logic [avd_pkg::SEG_W-1:0]    out_seg_units,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [avd_pkg::ADDR_W-1:0]   paddr,
  input  logic [avd_pkg::DATA_W-1:0]   pwdata,
  output logic [avd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import avd_pkg::*;

  logic [FS_W-1:0]     full_scale;
  logic                acc_rdy, acc_v;
  tag_t                acc_tag;
  logic [SAMPLE_W-1:0] acc_avg;
  logic                scl_rdy, scl_v;
  tag_t                scl_tag;
  logic [READ_W-1:0]   scl_reading;
  logic                dig_rdy;
  tag_t                dig_tag;

  // Configuration register
  avd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .full_scale (full_scale)
  );

  // Accumulate and average
  avd_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (in_valid),
    .in_sample (in_sample),
    .in_rdy    (acc_rdy),
    .out_v     (acc_v),
    .out_tag   (acc_tag),
    .out_avg   (acc_avg),
    .out_rdy   (scl_rdy)
  );

  // Scale to centivolts and latch
  avd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_v        (acc_v),
    .in_tag      (acc_tag),
    .in_avg      (acc_avg),
    .full_scale  (full_scale),
    .in_rdy      (scl_rdy),
    .out_v       (scl_v),
    .out_tag     (scl_tag),
    .out_reading (scl_reading),
    .out_rdy     (dig_rdy)
  );

  // Split digits and encode segments
  avd_digits u_digits (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_v        (scl_v),
    .in_tag      (scl_tag),
    .in_reading  (scl_reading),
    .in_rdy      (dig_rdy),
    .out_v       (out_valid),
    .out_tag     (dig_tag),
    .out_reading (out_reading_centivolts),
    .out_seg_h   (out_seg_hundreds),
    .out_seg_t   (out_seg_tens),
    .out_seg_u   (out_seg_units),
    .out_rdy     (!out_stall)
  );

  assign in_stall          = !acc_rdy;
  assign out_dac_code      = dig_tag.dac;
  assign out_average_ready = dig_tag.done;

endmodule

@@ design/avd_cfg.sv @@
// APB-style configuration register of the voltmeter display unit.
// Holds the full-scale reference in centivolts. Depends on avd_pkg.
module avd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [avd_pkg::ADDR_W-1:0] paddr,
  input  logic [avd_pkg::DATA_W-1:0] pwdata,
  output logic [avd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [avd_pkg::FS_W-1:0]   full_scale
);
  import avd_pkg::*;

  logic [FS_W-1:0] fs_r;
  logic [FS_W-1:0] fs_nxt;
  logic            wr_fs;

  assign pready = 1'b1;
  assign wr_fs  = psel && penable && pwrite && (paddr[2] == REG_FULL_SCALE);

  // Take the low bits of the written word
  assign fs_nxt = wr_fs ? pwdata[FS_W-1:0] : fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_RESET;
    end else begin
      fs_r <= fs_nxt;
    end
  end

  // Read back; unmapped words read as zero
  assign prdata     = (paddr[2] == REG_FULL_SCALE) ? DATA_W'(fs_r) : '0;
  assign full_scale = fs_r;

endmodule

@@ design/avd_accum.sv @@
// Accumulate stage: running sum and sample count, average at window end.
// One register stage with a valid bit. Depends on avd_pkg.
module avd_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_v,
  input  logic [avd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         in_rdy,
  output logic                         out_v,
  output avd_pkg::tag_t                out_tag,
  output logic [avd_pkg::SAMPLE_W-1:0] out_avg,
  input  logic                         out_rdy
);
  import avd_pkg::*;

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                v_r;
  tag_t                tag_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [SUM_W-1:0]    sum_full;
  logic                done;
  logic                adv;
  logic                take;

  assign adv  = !v_r || out_rdy;
  assign take = in_v && adv;

  // Window closes on the sample that finds the count all ones
  assign sum_full = sum_r + SUM_W'(in_sample);
  assign done     = &cnt_r;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (done) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_full;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      v_r   <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      if (adv) begin
        v_r <= in_v;
      end
    end
  end

  // Capture item payload; the average is the sum shifted down by the window
  always_ff @(posedge clk) begin
    if (take) begin
      tag_r.dac  <= in_sample[SAMPLE_W-1 -: DAC_W];
      tag_r.done <= done;
      avg_r      <= sum_full[SUM_W-1 -: SAMPLE_W];
    end
  end

  assign in_rdy  = adv;
  assign out_v   = v_r;
  assign out_tag = tag_r;
  assign out_avg = avg_r;

endmodule

@@ design/avd_scale.sv @@
// Scale stages: average times full scale, then divide by full code,
// saturate and latch the reading. Two register stages. Depends on avd_pkg.
module avd_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_v,
  input  avd_pkg::tag_t                in_tag,
  input  logic [avd_pkg::SAMPLE_W-1:0] in_avg,
  input  logic [avd_pkg::FS_W-1:0]     full_scale,
  output logic                         in_rdy,
  output logic                         out_v,
  output avd_pkg::tag_t                out_tag,
  output logic [avd_pkg::READ_W-1:0]   out_reading,
  input  logic                         out_rdy
);
  import avd_pkg::*;

  localparam int REM_W = SAMPLE_W + 1;
  localparam int QUO_W = FS_W + 1;

  logic              va_r, vb_r;
  tag_t              taga_r, tagb_r;
  logic [PROD_W-1:0] prod_r;
  logic [READ_W-1:0] latched_r, latched_nxt;
  logic              adva, advb;
  logic [FS_W-1:0]   q0;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  quot;
  logic [READ_W-1:0] sat;

  assign advb = !vb_r || out_rdy;
  assign adva = !va_r || advb;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (in_v && adva) begin
      taga_r <= in_tag;
      prod_r <= PROD_W'(in_avg) * PROD_W'(full_scale);
    end
  end

  // Divide by 65535: x = q0*65536 + lo, so x - q0*65535 = lo + q0,
  // which stays below twice the divisor; one correction step
  assign q0   = prod_r[PROD_W-1:SAMPLE_W];
  assign rem  = REM_W'(prod_r[SAMPLE_W-1:0]) + REM_W'(q0);
  assign quot = QUO_W'(q0) + QUO_W'(rem >= REM_W'(FULL_CODE));
  assign sat  = (quot > QUO_W'(MAX_READING)) ? READ_W'(MAX_READING) : quot[READ_W-1:0];

  // Latch the reading when an item that closed a window enters
  assign latched_nxt = (va_r && advb && taga_r.done) ? sat : latched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      latched_r <= '0;
    end else begin
      if (adva) begin
        va_r <= in_v;
      end
      if (advb) begin
        vb_r <= va_r;
      end
      latched_r <= latched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r && advb) begin
      tagb_r <= taga_r;
    end
  end

  assign in_rdy      = adva;
  assign out_v       = vb_r;
  assign out_tag     = tagb_r;
  assign out_reading = latched_r;

endmodule

@@ design/avd_digits.sv @@
// Digit stages: split the reading into decimal digits by reciprocal
// multiplies and encode the segments. Two register stages. Depends on avd_pkg.
module avd_digits (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_v,
  input  avd_pkg::tag_t              in_tag,
  input  logic [avd_pkg::READ_W-1:0] in_reading,
  output logic                       in_rdy,
  output logic                       out_v,
  output avd_pkg::tag_t              out_tag,
  output logic [avd_pkg::READ_W-1:0] out_reading,
  output logic [avd_pkg::SEG_W-1:0]  out_seg_h,
  output logic [avd_pkg::SEG_W-1:0]  out_seg_t,
  output logic [avd_pkg::SEG_W-1:0]  out_seg_u,
  input  logic                       out_rdy
);
  import avd_pkg::*;

  // r/100 = (r*41) >> 12 and r/10 = (r*205) >> 11, exact below 1000
  localparam int HM_W = 16;
  localparam int TM_W = 15;
  localparam int RM_W = 7;

  logic              vc_r, vd_r;
  tag_t              tagc_r, tagd_r;
  logic [READ_W-1:0] readc_r, readd_r;
  logic [3:0]        hund_r;
  logic [RM_W-1:0]   rem_r;
  logic [SEG_W-1:0]  segh_r, segt_r, segu_r;
  logic              advc, advd;
  logic [HM_W-1:0]   hm;
  logic [3:0]        hund;
  logic [READ_W-1:0] hx100, rem10;
  logic [TM_W-1:0]   tm;
  logic [3:0]        tens;
  logic [RM_W-1:0]   tx10, u7;

  assign advd = !vd_r || out_rdy;
  assign advc = !vc_r || advd;

  // Hundreds digit and remainder
  assign hm    = HM_W'(in_reading) * HM_W'(41);
  assign hund  = hm[HM_W-1 -: 4];
  assign hx100 = READ_W'(hund) * READ_W'(100);
  assign rem10 = in_reading - hx100;

  // Tens and units from the remainder
  assign tm   = TM_W'(rem_r) * TM_W'(205);
  assign tens = tm[TM_W-1 -: 4];
  assign tx10 = RM_W'(tens) * RM_W'(10);
  assign u7   = rem_r - tx10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (advc) begin
        vc_r <= in_v;
      end
      if (advd) begin
        vd_r <= vc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_v && advc) begin
      tagc_r  <= in_tag;
      readc_r <= in_reading;
      hund_r  <= hund;
      rem_r   <= rem10[RM_W-1:0];
    end
    if (vc_r && advd) begin
      tagd_r  <= tagc_r;
      readd_r <= readc_r;
      segh_r  <= seg_code(hund_r) & DP_MASK;
      segt_r  <= seg_code(tens);
      segu_r  <= seg_code(u7[3:0]);
    end
  end

  assign in_rdy      = advc;
  assign out_v       = vd_r;
  assign out_tag     = tagd_r;
  assign out_reading = readd_r;
  assign out_seg_h   = segh_r;
  assign out_seg_t   = segt_r;
  assign out_seg_u   = segu_r;

endmodule

@@ test/averaging_voltmeter_display_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for averaging_voltmeter_display_unit: a directed plan
// followed by random sample streams, checked against an in-bench meter model.
// Depends on avd_pkg and the design sources only.
module averaging_voltmeter_display_unit_tb;
  import avd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 10;
  // Worst case is roughly 1450 items, each behind a long gap and a long stall,
  // taken several times over
  localparam int LIMIT_CYCLES  = 400_000;

  localparam logic [ADDR_W-1:0] FS_ADDR    = {REG_FULL_SCALE, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_FULL_SCALE, 2'b00};

  localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };
  localparam logic [SEG_W-1:0] S0 = 8'hc0;
  localparam logic [SEG_W-1:0] S9 = 8'h90;
  localparam logic [SEG_W-1:0] H0 = S0 & DP_MASK;
  localparam logic [SEG_W-1:0] H9 = S9 & DP_MASK;

  typedef struct packed {
    logic [DAC_W-1:0]  dac;
    logic              ready;
    logic [READ_W-1:0] reading;
    logic [SEG_W-1:0]  seg_h;
    logic [SEG_W-1:0]  seg_t;
    logic [SEG_W-1:0]  seg_u;
  } display_t;

  typedef enum logic [1:0] {ROW_FEED, ROW_WRITE, ROW_READ} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
    logic [15:0]       reps;
    logic              typed;
    display_t          want;
  } plan_row_t;

  localparam display_t NONE = '0;

  // Directed plan: reset readback, edge samples and register writes inside
  // the first window, so the display still shows a reading of zero
  localparam int PLAN_ROWS = 25;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_READ,  FS_ADDR,    32'(FS_RESET),  16'd0,    1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'h0000,       16'd1,    1'b1, '{12'h000, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd1,    1'b1, '{12'hFFF, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'h8000,       16'd1,    1'b1, '{12'h800, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'h000F,       16'd1,    1'b1, '{12'h000, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'h0010,       16'd1,    1'b1, '{12'h001, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'h5555,       16'd1,    1'b1, '{12'h555, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'hAAAA,       16'd1,    1'b1, '{12'hAAA, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'h0000,       16'd100,  1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'h0000,       16'd1,    1'b1, '{12'h000, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_WRITE, FS_ADDR,    32'hFFFF_FFFF,  16'd0,    1'b0, NONE},
    '{ROW_READ,  FS_ADDR,    32'd1023,       16'd0,    1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd99,   1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd1,    1'b1, '{12'hFFF, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_FEED,  FS_ADDR,    32'h1234,       16'd1,    1'b1, '{12'h123, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_WRITE, SPARE_ADDR, 32'd5,          16'd0,    1'b0, NONE},
    '{ROW_READ,  FS_ADDR,    32'd1023,       16'd0,    1'b0, NONE},
    '{ROW_WRITE, FS_ADDR,    32'd0,          16'd0,    1'b0, NONE},
    '{ROW_READ,  FS_ADDR,    32'd0,          16'd0,    1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd48,   1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd1,    1'b1, '{12'hFFF, 1'b0, 10'd0, H0, S0, S0}},
    '{ROW_WRITE, FS_ADDR,    32'd999,        16'd0,    1'b0, NONE},
    '{ROW_READ,  FS_ADDR,    32'd999,        16'd0,    1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd49,   1'b0, NONE},
    '{ROW_FEED,  FS_ADDR,    32'hFFFF,       16'd1,    1'b1, '{12'hFFF, 1'b0, 10'd0, H0, S0, S0}}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DAC_W-1:0]    out_dac_code;
  logic                out_average_ready;
  logic [READ_W-1:0]   out_reading_centivolts;
  logic [SEG_W-1:0]    out_seg_hundreds;
  logic [SEG_W-1:0]    out_seg_tens;
  logic [SEG_W-1:0]    out_seg_units;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Typed expectation that travels with the item being driven
  logic     pin_on  = 1'b0;
  display_t pin_exp = '0;

  // Meter model state
  longint unsigned   acc_sum      = 0;
  int unsigned       acc_count    = 0;
  logic [READ_W-1:0] held_reading = '0;
  logic [FS_W-1:0]   fs_model     = FS_RESET;

  display_t shown_q [$];
  int       fail_count   = 0;
  int       result_index = 0;
  bit       steady_feed  = 1'b0;
  int       stall_left   = 0;
  int       stall_roll;
  display_t predicted;
  display_t observed;

  averaging_voltmeter_display_unit uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_sample              (in_sample),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_dac_code           (out_dac_code),
    .out_average_ready      (out_average_ready),
    .out_reading_centivolts (out_reading_centivolts),
    .out_seg_hundreds       (out_seg_hundreds),
    .out_seg_tens           (out_seg_tens),
    .out_seg_units          (out_seg_units),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Accumulate one sample, close the window when full, encode the held reading
  function automatic display_t advance_meter(input logic [SAMPLE_W-1:0] value);
    display_t        res;
    longint unsigned scaled;
    int unsigned     r;
    acc_sum   += value;
    acc_count += 1;
    res.ready  = 1'b0;
    if (acc_count >= (1 << LOG2_SAMPLES)) begin
      scaled = ((acc_sum >> LOG2_SAMPLES) * fs_model) / FULL_CODE;
      if (scaled > MAX_READING) scaled = MAX_READING;
      held_reading = READ_W'(scaled);
      acc_sum      = 0;
      acc_count    = 0;
      res.ready    = 1'b1;
    end
    r           = held_reading;
    res.dac     = value[SAMPLE_W-1 -: DAC_W];
    res.reading = held_reading;
    res.seg_h   = DIGIT_SEGS[(r / 100) % 10] & DP_MASK;
    res.seg_t   = DIGIT_SEGS[(r / 10) % 10];
    res.seg_u   = DIGIT_SEGS[r % 10];
    return res;
  endfunction

  function automatic string show(input display_t d);
    return $sformatf("dac=%h ready=%b reading=%0d seg=%h/%h/%h",
                     d.dac, d.ready, d.reading, d.seg_h, d.seg_t, d.seg_u);
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Track register writes and predict every accepted item
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == FS_ADDR)
        fs_model = pwdata[FS_W-1:0];
      if (in_valid && !in_stall) begin
        predicted = advance_meter(in_sample);
        shown_q.push_back(pin_on ? pin_exp : predicted);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      observed = {out_dac_code, out_average_ready, out_reading_centivolts,
                  out_seg_hundreds, out_seg_tens, out_seg_units};
      if (shown_q.size() == 0) begin
        note_fail($sformatf("result %0d with nothing pending: %s", result_index,
                            show(observed)));
      end else begin
        predicted = shown_q.pop_front();
        if (observed !== predicted)
          note_fail($sformatf("result %0d expected %s got %s", result_index,
                              show(predicted), show(observed)));
      end
      result_index++;
    end
  end

  // Result-side back-pressure: short runs mostly, some long stalls and long open stretches
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else if (stall_roll < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_roll < 97) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end else begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(40, 200);
      end
    end
  end

  // Offer one item after an optional gap and hold it until taken
  task automatic feed_sample(input logic [SAMPLE_W-1:0] value, input logic pinned,
                             input display_t want);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_feed || roll < 65) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    pin_on    <= pinned;
    pin_exp   <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop feeding and wait for every pending result, then let the pipe empty
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (shown_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      note_fail($sformatf("register %0d read expected %0d got %0d", addr, want, got));
  endtask

  // Timeout guard
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int                  style;
    int                  level;
    int                  spread;
    int                  len;
    int                  v;
    logic [FS_W-1:0]     fs;
    logic [DATA_W-1:0]   word;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    foreach (PLAN[i]) begin
      case (PLAN[i].kind)
        ROW_FEED: begin
          for (int k = 0; k < PLAN[i].reps; k++)
            feed_sample(PLAN[i].value[SAMPLE_W-1:0],
                        PLAN[i].typed && k == PLAN[i].reps - 1, PLAN[i].want);
        end
        ROW_WRITE: begin
          drain_results(SETTLE_CYCLES);
          reg_write(PLAN[i].addr, PLAN[i].value);
        end
        default: begin
          drain_results(SETTLE_CYCLES);
          check_register(PLAN[i].addr, PLAN[i].value);
        end
      endcase
    end

    // Random streams, each under its own full-scale setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: fs = FS_W'(1);
        1: fs = FS_W'(999);
        2: fs = FS_W'(1023);
        default: fs = FS_W'($urandom_range(1, 1023));
      endcase
      drain_results(SETTLE_CYCLES);
      word = $urandom;
      word[FS_W-1:0] = fs;
      reg_write(FS_ADDR, word);
      // Idle the bus before the readback
      @(posedge clk);
      check_register(FS_ADDR, DATA_W'(fs));

      steady_feed = ($urandom_range(0, 3) == 0);
      style  = $urandom_range(0, 3);
      level  = $urandom_range(0, 65535);
      spread = $urandom_range(0, 2048);
      len    = $urandom_range(76, 114);
      for (int i = 0; i < len; i++) begin
        // Hold off the sender until everything in flight has come back
        if (ph % 2 == 0 && i == len / 2) drain_results(0);
        if ($urandom_range(0, 31) == 0 || style == 0) begin
          v = $urandom_range(0, 65535);
        end else if (style == 3) begin
          case ($urandom_range(0, 2))
            0: v = 0;
            1: v = 65535;
            default: v = $urandom_range(0, 65535);
          endcase
        end else begin
          v = level + $urandom_range(0, 2 * spread) - spread;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
        end
        feed_sample(SAMPLE_W'(v), 1'b0, NONE);
      end
    end

    drain_results(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/avd_pkg.sv
design/avd_cfg.sv
design/avd_accum.sv
design/avd_scale.sv
design/avd_digits.sv
design/averaging_voltmeter_display_unit.sv
test/averaging_voltmeter_display_unit_tb.sv
